[rtl/pist_pkg.sv]
// shared types, codes and constants of the point-in-shape test block
package pist_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;

  localparam logic [CFG_IDX_W-1:0] REG_SHAPE_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_LENGTH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_WIDTH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CIRCLE_RADIUS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT  = 3'd4;

  localparam int MODE_W   = 2;
  localparam int RECT_W   = 15;
  localparam int RADIUS_W = 23;
  localparam int VCOUNT_W = 7;
  localparam int IDX_W    = 6;

  localparam logic [MODE_W-1:0] MODE_CIRCLE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RECT   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_POLY   = 2'd2;

  localparam logic [MODE_W-1:0]   RST_SHAPE_MODE    = MODE_RECT;
  localparam logic [RECT_W-1:0]   RST_RECT_LENGTH   = 15'd10;
  localparam logic [RECT_W-1:0]   RST_RECT_WIDTH    = 15'd10;
  localparam logic [RADIUS_W-1:0] RST_CIRCLE_RADIUS = 23'd0;
  localparam logic [VCOUNT_W-1:0] RST_VERTEX_COUNT  = 7'd0;

  // request kinds
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // fixed point: 8 fraction bits
  localparam int FRAC_BITS = 8;
  localparam int DIA_W     = RADIUS_W + 1;
  localparam int DXY_W     = DIA_W + 2;
  localparam int SQ_W      = 2 * DXY_W;

  // operations handed from front to back
  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_WRITE  = 3'd0;
  localparam logic [OP_W-1:0] OP_ZERO   = 3'd1;
  localparam logic [OP_W-1:0] OP_RECT   = 3'd2;
  localparam logic [OP_W-1:0] OP_CIRCLE = 3'd3;
  localparam logic [OP_W-1:0] OP_POLY   = 3'd4;

  typedef struct packed {
    logic [MODE_W-1:0]   shape_mode;
    logic [RECT_W-1:0]   rect_length;
    logic [RECT_W-1:0]   rect_width;
    logic [RADIUS_W-1:0] circle_radius;
    logic [VCOUNT_W-1:0] vertex_count;
  } cfg_t;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] slot;
  } item_ctl_t;

endpackage

[rtl/pist_front.sv]
// front end: accepts request beats and classifies them into back-end operations
module pist_front #(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_WIDTH  = 24
) (
  input  pist_pkg::cfg_t                 cfg,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_req_type,
  input  logic [pist_pkg::IDX_W-1:0]     in_vertex_index,
  input  logic signed [COORD_WIDTH-1:0]  in_coord_x,
  input  logic signed [COORD_WIDTH-1:0]  in_coord_y,
  output logic                           push_valid,
  input  logic                           push_ready,
  output pist_pkg::item_ctl_t            push_ctl,
  output logic signed [COORD_WIDTH-1:0]  push_x,
  output logic signed [COORD_WIDTH-1:0]  push_y
);
  import pist_pkg::*;

  logic drop;
  logic [OP_W-1:0] op;

  always_comb begin
    drop = 1'b0;
    op   = OP_ZERO;
    if (in_req_type == REQ_WRITE) begin
      op   = OP_WRITE;
      // slots past the table are swallowed
      drop = !(32'(in_vertex_index) < MAX_VERTICES);
    end else begin
      unique case (cfg.shape_mode)
        MODE_CIRCLE: op = OP_CIRCLE;
        MODE_RECT:   op = OP_RECT;
        MODE_POLY:   op = (cfg.vertex_count == '0) ? OP_ZERO : OP_POLY;
        default:     op = OP_ZERO;
      endcase
    end
  end

  assign in_ready      = push_ready;
  assign push_valid    = in_valid && !drop;
  assign push_ctl.op   = op;
  assign push_ctl.slot = in_vertex_index;
  assign push_x        = in_coord_x;
  assign push_y        = in_coord_y;

endmodule

[rtl/pist_fifo.sv]
// short queue between front and back end
module pist_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_valid,
  output logic         wr_ready,
  input  logic [W-1:0] wr_data,
  output logic         rd_valid,
  input  logic         rd_ready,
  output logic [W-1:0] rd_data
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wptr_r, rptr_r;
  logic [CW-1:0] cnt_r;
  logic          do_wr, do_rd;

  assign wr_ready = (cnt_r != CW'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_wr) begin
        wptr_r <= (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + PW'(1);
      end
      if (do_rd) begin
        rptr_r <= (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + PW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

endmodule

[rtl/pist_back.sv]
// back end: vertex table, rectangle and circle tests, polygon edge walk, result register
module pist_back #(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_WIDTH  = 24
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  pist_pkg::cfg_t                 cfg,
  input  logic                           q_valid,
  output logic                           q_ready,
  input  pist_pkg::item_ctl_t            q_ctl,
  input  logic signed [COORD_WIDTH-1:0]  q_x,
  input  logic signed [COORD_WIDTH-1:0]  q_y,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_inside_res
);
  import pist_pkg::*;

  localparam int AW    = $clog2(MAX_VERTICES);
  localparam int NW    = $clog2(MAX_VERTICES + 2);
  localparam int DW    = COORD_WIDTH + 1;
  localparam int PW    = 2 * DW;
  localparam int CMP_W = ((COORD_WIDTH > 25) ? COORD_WIDTH : 25) + 2;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CALC = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_WALK = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0] state_r;
  logic [OP_W-1:0] op_r;
  logic signed [COORD_WIDTH-1:0] px_r, py_r;
  logic res_r;

  // circle path
  logic inbox_r;
  logic signed [DXY_W-1:0] dx_r, dy_r;
  logic [SQ_W-1:0] sqx_r, sqy_r;
  logic [2*DIA_W-1:0] dd_r;

  // vertex table
  logic signed [COORD_WIDTH-1:0] mem_x [MAX_VERTICES];
  logic signed [COORD_WIDTH-1:0] mem_y [MAX_VERTICES];
  logic signed [COORD_WIDTH-1:0] rd_x_r, rd_y_r;

  // edge walk pipeline
  logic [NW-1:0] rd_cnt_r;
  logic v1_r, first1_r, e2_r, e3_r;
  logic signed [COORD_WIDTH-1:0] prev_x_r, prev_y_r;
  logic signed [COORD_WIDTH-1:0] minx_r, maxx_r, miny_r, maxy_r;
  logic strad2_r, strad3_r, dpos3_r, parity_r;
  logic signed [DW-1:0] dxp2_r, d2_r, dxx2_r, dyp2_r;
  logic signed [PW-1:0] p1_r, p2_r;

  logic out_valid_r, out_inside_r;

  logic pop, issue, walk_empty, slot_free, load_out, crosses, poly_in;
  logic rect_in, circ_box, circ_le, strad1;
  logic [NW-1:0] n_eff;
  logic [AW-1:0] rd_addr, wr_addr;
  logic signed [CMP_W-1:0] px_w, py_w, lx_w, ly_w, box_w, dxw, dyw;
  logic [DIA_W-1:0] dia, box;

  assign q_ready = (state_r == S_IDLE);
  assign pop     = q_ready && q_valid;

  assign n_eff = (32'(cfg.vertex_count) > MAX_VERTICES) ? NW'(MAX_VERTICES)
                                                         : NW'(cfg.vertex_count);

  // read order n-1, 0, 1, .. n-1 so each read closes an edge with the one before
  assign issue      = (state_r == S_WALK) && (rd_cnt_r <= n_eff);
  assign rd_addr    = (rd_cnt_r == '0) ? AW'(n_eff - NW'(1)) : AW'(rd_cnt_r - NW'(1));
  assign wr_addr    = AW'(32'(q_ctl.slot));
  assign walk_empty = !issue && !v1_r && !e2_r && !e3_r;

  // rectangle
  assign px_w    = CMP_W'(px_r);
  assign py_w    = CMP_W'(py_r);
  assign lx_w    = CMP_W'({cfg.rect_length, FRAC_BITS'(0)});
  assign ly_w    = CMP_W'({cfg.rect_width, FRAC_BITS'(0)});
  assign rect_in = !px_r[COORD_WIDTH-1] && !py_r[COORD_WIDTH-1] && (px_w <= lx_w)
                   && (py_w <= ly_w);

  // circle, in doubled coordinates
  assign dia      = {cfg.circle_radius, 1'b0};
  assign box      = {dia[DIA_W-1:FRAC_BITS], FRAC_BITS'(0)};
  assign box_w    = CMP_W'(box);
  assign circ_box = !px_r[COORD_WIDTH-1] && !py_r[COORD_WIDTH-1] && (px_w <= box_w)
                    && (py_w <= box_w);
  assign dxw      = (px_w <<< 1) - box_w;
  assign dyw      = (py_w <<< 1) - box_w;
  assign circ_le  = ({1'b0, sqx_r} + {1'b0, sqy_r}) <= (SQ_W + 1)'(dd_r);

  // polygon
  assign strad1  = (rd_y_r > py_r) != (prev_y_r > py_r);
  assign crosses = dpos3_r ? (p1_r < p2_r) : (p2_r < p1_r);
  assign poly_in = parity_r && !(px_r < minx_r || py_r < miny_r || px_r > maxx_r
                                 || py_r > maxy_r);

  assign slot_free = !out_valid_r || out_ready;
  assign load_out  = (state_r == S_DONE) && slot_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_cnt_r    <= '0;
      v1_r        <= 1'b0;
      first1_r    <= 1'b0;
      e2_r        <= 1'b0;
      e3_r        <= 1'b0;
      parity_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r     <= issue;
      first1_r <= issue && (rd_cnt_r == '0);
      e2_r     <= v1_r && !first1_r;
      e3_r     <= e2_r;
      if (issue) begin
        rd_cnt_r <= rd_cnt_r + NW'(1);
      end
      if (e3_r && strad3_r && crosses) begin
        parity_r <= !parity_r;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (pop && q_ctl.op == OP_ZERO) begin
            state_r <= S_DONE;
          end else if (pop && q_ctl.op != OP_WRITE) begin
            state_r <= S_CALC;
          end
        end
        S_CALC: begin
          rd_cnt_r <= '0;
          parity_r <= 1'b0;
          if (op_r == OP_CIRCLE) begin
            state_r <= S_MUL;
          end else if (op_r == OP_POLY) begin
            state_r <= S_WALK;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_MUL:  state_r <= S_CMP;
        S_CMP:  state_r <= S_DONE;
        S_WALK: begin
          if (walk_empty && rd_cnt_r > n_eff) begin
            state_r <= S_FIN;
          end
        end
        S_FIN:  state_r <= S_DONE;
        S_DONE: begin
          if (slot_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      op_r <= q_ctl.op;
      px_r <= q_x;
      py_r <= q_y;
    end
    if (pop && q_ctl.op == OP_ZERO) begin
      res_r <= 1'b0;
    end else if (state_r == S_CALC) begin
      res_r <= rect_in;
    end else if (state_r == S_CMP) begin
      res_r <= inbox_r && circ_le;
    end else if (state_r == S_FIN) begin
      res_r <= poly_in;
    end
    if (state_r == S_CALC) begin
      inbox_r <= circ_box;
      dx_r    <= $signed(dxw[DXY_W-1:0]);
      dy_r    <= $signed(dyw[DXY_W-1:0]);
    end
    if (state_r == S_MUL) begin
      sqx_r <= dx_r * dx_r;
      sqy_r <= dy_r * dy_r;
      dd_r  <= dia * dia;
    end
    if (load_out) begin
      out_inside_r <= res_r;
    end
  end

  // edge pipeline: differences, then products, then parity
  always_ff @(posedge clk) begin
    if (v1_r) begin
      prev_x_r <= rd_x_r;
      prev_y_r <= rd_y_r;
      if (first1_r) begin
        minx_r <= rd_x_r;
        maxx_r <= rd_x_r;
        miny_r <= rd_y_r;
        maxy_r <= rd_y_r;
      end else begin
        if (rd_x_r < minx_r) minx_r <= rd_x_r;
        if (rd_x_r > maxx_r) maxx_r <= rd_x_r;
        if (rd_y_r < miny_r) miny_r <= rd_y_r;
        if (rd_y_r > maxy_r) maxy_r <= rd_y_r;
      end
    end
    strad2_r <= strad1;
    dxp2_r   <= DW'(px_r) - DW'(rd_x_r);
    d2_r     <= DW'(prev_y_r) - DW'(rd_y_r);
    dxx2_r   <= DW'(prev_x_r) - DW'(rd_x_r);
    dyp2_r   <= DW'(py_r) - DW'(rd_y_r);
    strad3_r <= strad2_r;
    dpos3_r  <= !d2_r[DW-1] && (d2_r != '0);
    p1_r     <= dxp2_r * d2_r;
    p2_r     <= dxx2_r * dyp2_r;
  end

  always_ff @(posedge clk) begin
    if (pop && q_ctl.op == OP_WRITE) begin
      mem_x[wr_addr] <= q_x;
      mem_y[wr_addr] <= q_y;
    end
    rd_x_r <= mem_x[rd_addr];
    rd_y_r <= mem_y[rd_addr];
  end

  assign out_valid      = out_valid_r;
  assign out_inside_res = out_inside_r;

endmodule

[rtl/point_in_shape_test_core.sv]
// top level of the point-in-shape test block: configuration registers and wiring
//
// Request beats on in_* carry either a vertex write (in_req_type 0), which stores
// in_coord_x/in_coord_y in slot in_vertex_index and gives no result, or a query
// point (in_req_type 1), which gives one beat on out_* with out_inside_res set
// when the point lies in the shape chosen by shape_mode.
// Configuration registers are written through cfg_we/cfg_index/cfg_wdata; the user
// must write them only while no work is pending, as the block does not enforce it.
// A front end classifies each beat into a two-entry queue; the back end runs one
// operation at a time. The edge walk of a polygon query reads one vertex a cycle
// from the vertex table.
// The result waits in an output register while the back end takes the next
// beat; a stalled receiver holds the back end only once its next result is done,
// and the queue then fills and in_ready drops.
// Reset clears the queue, the output and the registers to their defaults; the
// vertex table is not cleared and holds no defined value until written.
module point_in_shape_test_core #(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_WIDTH  = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [pist_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pist_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_req_type,
  input  logic [pist_pkg::IDX_W-1:0]        in_vertex_index,
  input  logic signed [COORD_WIDTH-1:0]     in_coord_x,
  input  logic signed [COORD_WIDTH-1:0]     in_coord_y,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_inside_res
);
  import pist_pkg::*;

  localparam int QW      = $bits(item_ctl_t) + 2 * COORD_WIDTH;
  localparam int Q_DEPTH = 2;

  cfg_t cfg_r;

  logic                          push_valid, push_ready, q_valid, q_ready;
  item_ctl_t                     push_ctl, q_ctl;
  logic signed [COORD_WIDTH-1:0] push_x, push_y, q_x, q_y;
  logic [QW-1:0]                 q_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.shape_mode    <= RST_SHAPE_MODE;
      cfg_r.rect_length   <= RST_RECT_LENGTH;
      cfg_r.rect_width    <= RST_RECT_WIDTH;
      cfg_r.circle_radius <= RST_CIRCLE_RADIUS;
      cfg_r.vertex_count  <= RST_VERTEX_COUNT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SHAPE_MODE:    cfg_r.shape_mode    <= cfg_wdata[MODE_W-1:0];
        REG_RECT_LENGTH:   cfg_r.rect_length   <= cfg_wdata[RECT_W-1:0];
        REG_RECT_WIDTH:    cfg_r.rect_width    <= cfg_wdata[RECT_W-1:0];
        REG_CIRCLE_RADIUS: cfg_r.circle_radius <= cfg_wdata[RADIUS_W-1:0];
        REG_VERTEX_COUNT:  cfg_r.vertex_count  <= cfg_wdata[VCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  pist_front #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_WIDTH  (COORD_WIDTH)
  ) u_front (
    .cfg             (cfg_r),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_vertex_index (in_vertex_index),
    .in_coord_x      (in_coord_x),
    .in_coord_y      (in_coord_y),
    .push_valid      (push_valid),
    .push_ready      (push_ready),
    .push_ctl        (push_ctl),
    .push_x          (push_x),
    .push_y          (push_y)
  );

  pist_fifo #(
    .W     (QW),
    .DEPTH (Q_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_data  ({push_ctl, push_x, push_y}),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_data)
  );

  assign q_ctl = q_data[QW-1 -: $bits(item_ctl_t)];
  assign q_x   = $signed(q_data[2*COORD_WIDTH-1 -: COORD_WIDTH]);
  assign q_y   = $signed(q_data[COORD_WIDTH-1:0]);

  pist_back #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_WIDTH  (COORD_WIDTH)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .q_valid        (q_valid),
    .q_ready        (q_ready),
    .q_ctl          (q_ctl),
    .q_x            (q_x),
    .q_y            (q_y),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_inside_res (out_inside_res)
  );

endmodule

[rtl/pist_checker.sv]
// port-level checks of the point-in-shape test block and their binding
module pist_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_req_type,
  input logic out_valid,
  input logic out_ready,
  input logic out_inside_res
);
  import pist_pkg::*;

  logic [3:0] pend_r;
  logic       q_acc, o_acc;

  assign q_acc = in_valid && in_ready && (in_req_type == REQ_QUERY);
  assign o_acc = out_valid && out_ready;

  // queries taken whose result beat is not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (q_acc && !o_acc) begin
      pend_r <= pend_r + 4'd1;
    end else if (o_acc && !q_acc && pend_r != '0) begin
      pend_r <= pend_r - 4'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_inside_res))
    else $error("result beat changed while stalled");

  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != '0)
    else $error("result beat without a pending query");

  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 4'd4)
    else $error("more queries in flight than the block can hold");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind point_in_shape_test_core pist_checker u_pist_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_req_type    (in_req_type),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_inside_res (out_inside_res)
);
